FILE: src/spf_pkg.sv
// package for the scan-line span fill block
// constants and the request type codes; no dependencies
`default_nettype none
package spf_pkg;
    localparam int MaxVertices  = 16;
    localparam int MaxCrossings = 16;
    localparam int CoordBits    = 12;
    localparam int CountBits    = 5;
    localparam logic ReqVertex  = 1'b0;
    localparam logic ReqScan    = 1'b1;
endpackage
`default_nettype wire

FILE: src/spf_sort_cell.sv
// one cell of the insertion sort chain: takes the new value or its left neighbor's value
// depends on spf_pkg for widths
`default_nettype none
module spf_sort_cell #(
    parameter int COORD_BITS = spf_pkg::CoordBits
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_clear,
    input  wire logic                  i_shift,
    input  wire logic [COORD_BITS-1:0] i_value,
    input  wire logic                  i_prev_gt,
    input  wire logic                  i_prev_valid,
    input  wire logic [COORD_BITS-1:0] i_prev_value,
    output logic                       o_gt,
    output logic                       o_valid,
    output logic [COORD_BITS-1:0]      o_value
);
    logic                  r_valid;
    logic [COORD_BITS-1:0] r_value;
    logic                  w_gt;

    // the new value goes at or before this cell; cells past the slot shift right
    assign w_gt    = !r_valid || i_value < r_value;
    assign o_gt    = w_gt;
    assign o_valid = r_valid;
    assign o_value = r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= 1'b0;
        end else if (i_shift && w_gt) begin
            r_valid <= i_prev_gt ? i_prev_valid : 1'b1;
        end
        if (i_shift && w_gt) begin
            r_value <= i_prev_gt ? i_prev_value : i_value;
        end
    end
endmodule
`default_nettype wire

FILE: src/spf_divider.sv
// restoring divider, one quotient bit per cycle, unsigned operands
// width set by its parameter; no dependencies
`default_nettype none
module spf_divider #(
    parameter int W = 24
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_num,
    input  wire logic [W-1:0] i_den,
    output logic              o_done,
    output logic [W-1:0]      o_quot
);
    localparam int CntBits = $clog2(W + 1);
    logic [W-1:0]       r_rem;
    logic [W-1:0]       r_quot;
    logic [W-1:0]       r_den;
    logic [CntBits-1:0] r_cnt;
    logic               r_busy;
    logic [W:0]         w_trial;
    logic [W:0]         w_diff;

    assign w_trial = {r_rem, r_quot[W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign o_quot  = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntBits'(W);
                r_rem  <= '0;
                r_quot <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (!w_diff[W]) begin
                    r_rem <= w_diff[W-1:0];
                end else begin
                    r_rem <= w_trial[W-1:0];
                end
                r_quot <= {r_quot[W-2:0], !w_diff[W]};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CntBits'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

FILE: src/scanline_polygon_span_fill_top.sv
// Scan-line polygon span fill. A vertex write (req_type 0) is taken only while idle. A scan
// request walks vertex_count edges, capped at MAX_VERTICES; each crossed edge goes through
// the shared bit-serial divider. Crossings enter a chain of MAX_CROSSINGS sort cells, one
// per crossing. The spans then leave one per cycle on o_span_valid, which cannot be
// stalled; busy drops in the cycle that shows the last span (marked by o_last_span).
// depends on spf_pkg, spf_divider, spf_sort_cell
`default_nettype none
module scanline_polygon_span_fill_top #(
    parameter int MAX_VERTICES  = spf_pkg::MaxVertices,
    parameter int MAX_CROSSINGS = spf_pkg::MaxCrossings,
    parameter int COORD_BITS    = spf_pkg::CoordBits
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  i_req_type,
    input  wire logic [3:0]            i_vertex_index,
    input  wire logic [COORD_BITS-1:0] i_vertex_x,
    input  wire logic [COORD_BITS-1:0] i_vertex_y,
    input  wire logic [COORD_BITS-1:0] i_scan_y,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [4:0]            i_cfg_data,
    output logic                       o_span_valid,
    output logic [COORD_BITS-1:0]      o_span_start,
    output logic [COORD_BITS-1:0]      o_span_end,
    output logic [COORD_BITS-1:0]      o_span_row,
    output logic                       o_no_span,
    output logic                       o_last_span
);
    localparam int VIdxBits = $clog2(MAX_VERTICES);
    localparam int VCntBits = $clog2(MAX_VERTICES + 1);
    localparam int XCntBits = $clog2(MAX_CROSSINGS + 1);
    localparam int XIdxBits = $clog2(MAX_CROSSINGS);
    localparam int DivW     = 2 * COORD_BITS;

    localparam logic [2:0] StIdle  = 3'd0;
    localparam logic [2:0] StFetch = 3'd1;
    localparam logic [2:0] StTest  = 3'd2;
    localparam logic [2:0] StMul   = 3'd3;
    localparam logic [2:0] StDiv   = 3'd4;
    localparam logic [2:0] StIns   = 3'd5;
    localparam logic [2:0] StEmit  = 3'd6;

    logic [COORD_BITS-1:0] r_vx [MAX_VERTICES];
    logic [COORD_BITS-1:0] r_vy [MAX_VERTICES];
    logic [4:0]            r_vcount;
    logic [2:0]            r_state;
    logic [VCntBits-1:0]   r_n;
    logic [VCntBits-1:0]   r_edge;
    logic [COORD_BITS-1:0] r_row;
    logic [COORD_BITS-1:0] r_x1, r_y1, r_x2, r_y2;
    logic [XCntBits-1:0]   r_cnt;
    logic [XCntBits-1:0]   r_emit;
    logic                  r_neg;
    logic [DivW-1:0]       r_num;
    logic [COORD_BITS-1:0] r_den;
    logic [COORD_BITS-1:0] r_cross;
    logic                  r_ins_valid;

    // edge fetch
    logic [VCntBits-1:0] w_next;
    logic [VIdxBits-1:0] w_widx;
    assign w_next = (r_edge + 1'b1 == r_n) ? '0 : r_edge + 1'b1;
    assign w_widx = VIdxBits'(i_vertex_index);

    always_ff @(posedge i_clk) begin
        if (start && !busy && i_req_type == spf_pkg::ReqVertex
            && int'(i_vertex_index) < MAX_VERTICES) begin
            r_vx[w_widx] <= i_vertex_x;
            r_vy[w_widx] <= i_vertex_y;
        end
        if (r_state == StFetch) begin
            r_x1 <= r_vx[r_edge[VIdxBits-1:0]];
            r_y1 <= r_vy[r_edge[VIdxBits-1:0]];
            r_x2 <= r_vx[w_next[VIdxBits-1:0]];
            r_y2 <= r_vy[w_next[VIdxBits-1:0]];
        end
    end

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_vcount <= i_cfg_data;
        end
    end

    // crossing math: |(y-y1)*(x2-x1)| / |y2-y1|, sign applied after
    logic                  w_cross;
    logic [COORD_BITS:0]   w_dy, w_dx, w_dd;
    logic [COORD_BITS-1:0] w_dy_abs, w_dx_abs, w_dd_abs;
    logic                  w_div_done;
    logic [DivW-1:0]       w_quot;
    logic [COORD_BITS-1:0] w_q;

    assign w_cross = (r_y1 <= r_row && r_y2 > r_row) || (r_y2 <= r_row && r_y1 > r_row);
    assign w_dy    = {1'b0, r_row} - {1'b0, r_y1};
    assign w_dx    = {1'b0, r_x2} - {1'b0, r_x1};
    assign w_dd    = {1'b0, r_y2} - {1'b0, r_y1};
    assign w_dy_abs = w_dy[COORD_BITS] ? COORD_BITS'(-w_dy) : w_dy[COORD_BITS-1:0];
    assign w_dx_abs = w_dx[COORD_BITS] ? COORD_BITS'(-w_dx) : w_dx[COORD_BITS-1:0];
    assign w_dd_abs = w_dd[COORD_BITS] ? COORD_BITS'(-w_dd) : w_dd[COORD_BITS-1:0];
    // quotient is bounded by |x2-x1|, so the low bits carry it
    assign w_q = w_quot[COORD_BITS-1:0];

    spf_divider #(.W(DivW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == StMul),
        .i_num   (r_num),
        .i_den   ({{COORD_BITS{1'b0}}, r_den}),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // sort chain: the new crossing is shown to every cell at once
    logic                  w_gt   [MAX_CROSSINGS];
    logic                  w_sv   [MAX_CROSSINGS];
    logic [COORD_BITS-1:0] w_sval [MAX_CROSSINGS];
    logic                  w_clear;
    logic                  w_shift;

    assign w_clear = start && !busy;
    assign w_shift = r_ins_valid;

    for (genvar g = 0; g < MAX_CROSSINGS; g++) begin : g_cell
        spf_sort_cell #(.COORD_BITS(COORD_BITS)) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_clear      (w_clear),
            .i_shift      (w_shift),
            .i_value      (r_cross),
            .i_prev_gt    ((g == 0) ? 1'b0 : w_gt[(g == 0) ? 0 : g - 1]),
            .i_prev_valid ((g == 0) ? 1'b0 : w_sv[(g == 0) ? 0 : g - 1]),
            .i_prev_value ((g == 0) ? '0 : w_sval[(g == 0) ? 0 : g - 1]),
            .o_gt         (w_gt[g]),
            .o_valid      (w_sv[g]),
            .o_value      (w_sval[g])
        );
    end

    logic [XCntBits-1:0] w_pairs;
    assign w_pairs = r_cnt >> 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= StIdle;
            r_ins_valid  <= 1'b0;
            r_cnt        <= '0;
            o_span_valid <= 1'b0;
        end else begin
            r_ins_valid  <= 1'b0;
            o_span_valid <= 1'b0;
            unique case (r_state)
                StIdle: begin
                    if (start && i_req_type == spf_pkg::ReqScan) begin
                        r_row  <= i_scan_y;
                        r_edge <= '0;
                        r_cnt  <= '0;
                        r_emit <= '0;
                        r_n    <= (int'(r_vcount) > MAX_VERTICES) ? VCntBits'(MAX_VERTICES)
                                                                  : VCntBits'(r_vcount);
                        r_state <= StIns;
                    end
                end
                StFetch: r_state <= StTest;
                StTest: begin
                    if (w_cross) begin
                        r_neg   <= w_dy[COORD_BITS] ^ w_dx[COORD_BITS] ^ w_dd[COORD_BITS];
                        r_num   <= {{COORD_BITS{1'b0}}, w_dy_abs}
                                 * {{COORD_BITS{1'b0}}, w_dx_abs};
                        r_den   <= w_dd_abs;
                        r_state <= StMul;
                    end else begin
                        r_edge  <= r_edge + 1'b1;
                        r_state <= StIns;
                    end
                end
                StMul: r_state <= StDiv;
                StDiv: begin
                    if (w_div_done) begin
                        r_cross <= r_neg ? r_x1 - w_q : r_x1 + w_q;
                        if (r_cnt < XCntBits'(MAX_CROSSINGS)) begin
                            r_ins_valid <= 1'b1;
                            r_cnt       <= r_cnt + 1'b1;
                        end
                        r_edge  <= r_edge + 1'b1;
                        r_state <= StIns;
                    end
                end
                StIns: begin
                    // let a pending insert settle, then fetch the next edge or, after the last edge, emit
                    if (r_edge == r_n) begin
                        r_state <= StEmit;
                    end else begin
                        r_state <= StFetch;
                    end
                end
                StEmit: begin
                    o_span_valid <= 1'b1;
                    o_span_row   <= r_row;
                    if (w_pairs == '0) begin
                        o_span_start <= '0;
                        o_span_end   <= '0;
                        o_no_span    <= 1'b1;
                        o_last_span  <= 1'b1;
                        r_state      <= StIdle;
                    end else begin
                        o_span_start <= w_sval[r_emit[XIdxBits-1:0]];
                        o_span_end   <= w_sval[XIdxBits'(r_emit + 1'b1)];
                        o_no_span    <= 1'b0;
                        o_last_span  <= (r_emit + 2'd2 >= (w_pairs << 1));
                        r_emit       <= r_emit + 2'd2;
                        if (r_emit + 2'd2 >= (w_pairs << 1)) begin
                            r_state <= StIdle;
                        end
                    end
                end
                default: r_state <= StIdle;
            endcase
        end
    end

    assign busy = (r_state != StIdle);
endmodule
`default_nettype wire

FILE: tb/sv/spf_span_checker.sv
// span checker for the scan-line span fill block: watches the request, register
// and span channels, predicts spans and counts mismatches; depends on spf_pkg
`timescale 1ns / 100ps
module spf_span_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic        i_req_type,
    input  wire logic [3:0]  i_vertex_index,
    input  wire logic [11:0] i_vertex_x,
    input  wire logic [11:0] i_vertex_y,
    input  wire logic [11:0] i_scan_y,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [4:0]  i_cfg_data,
    input  wire logic        i_span_valid,
    input  wire logic [11:0] i_span_start,
    input  wire logic [11:0] i_span_end,
    input  wire logic [11:0] i_span_row,
    input  wire logic        i_no_span,
    input  wire logic        i_last_span,
    output int               o_fail_count,
    output int               o_pending
);
    typedef struct packed {
        logic [11:0] span_start;
        logic [11:0] span_end;
        logic [11:0] row;
        logic        no_span;
        logic        last;
    } span_t;

    logic [11:0] vx [spf_pkg::MaxVertices];
    logic [11:0] vy [spf_pkg::MaxVertices];
    logic [4:0]  num_vertices;
    span_t       span_queue [$];
    int          fail_count;
    int          pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    task automatic predict_spans(input logic [11:0] row);
        longint xs [$];
        longint x1, y1, x2, y2, yy, xc, t;
        int     n, j, k, pairs;
        span_t  s;
        n  = (num_vertices > spf_pkg::MaxVertices) ? spf_pkg::MaxVertices : num_vertices;
        yy = row;
        for (int i = 0; i < n; i++) begin
            j  = (i + 1 == n) ? 0 : i + 1;
            x1 = vx[i]; y1 = vy[i]; x2 = vx[j]; y2 = vy[j];
            if ((y1 <= yy && y2 > yy) || (y2 <= yy && y1 > yy)) begin
                // longint division truncates toward zero
                xc = x1 + ((yy - y1) * (x2 - x1)) / (y2 - y1);
                if (xs.size() < spf_pkg::MaxCrossings) xs.push_back(xc & 12'hfff);
            end
        end
        for (int i = 1; i < xs.size(); i++) begin
            t = xs[i];
            k = i;
            while (k > 0 && xs[k-1] > t) begin
                xs[k] = xs[k-1];
                k--;
            end
            xs[k] = t;
        end
        pairs = xs.size() / 2;
        if (pairs == 0) begin
            s = '{12'd0, 12'd0, row, 1'b1, 1'b1};
            span_queue.push_back(s);
        end
        for (int p = 0; p < pairs; p++) begin
            s = '{xs[2*p][11:0], xs[2*p+1][11:0], row, 1'b0, p + 1 == pairs};
            span_queue.push_back(s);
        end
    endtask

    always @(posedge i_clk) begin
        span_t got, exp_span;
        if (!i_rst_n) begin
            num_vertices = '0;
            fail_count   = 0;
            span_queue.delete();
        end else begin
            if (i_span_valid) begin
                got = '{i_span_start, i_span_end, i_span_row, i_no_span, i_last_span};
                if (span_queue.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected span %p", got);
                end else begin
                    exp_span = span_queue.pop_front();
                    if (got !== exp_span) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("span mismatch: expected %p, got %p", exp_span, got);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) num_vertices = i_cfg_data;
            if (start && !busy) begin
                if (i_req_type == spf_pkg::ReqVertex) begin
                    vx[i_vertex_index] = i_vertex_x;
                    vy[i_vertex_index] = i_vertex_y;
                end else begin
                    predict_spans(i_scan_y);
                end
            end
        end
        pending_count = span_queue.size();
    end
endmodule

FILE: tb/sv/tb_scanline_polygon_span_fill_top.sv
// testbench top for the scan-line span fill block: drives vertex writes, vertex
// counts and scan lines; depends on spf_pkg, the block and spf_span_checker
`timescale 1ns / 100ps
module tb_scanline_polygon_span_fill_top;
    localparam int DrainCycles = 600;
    localparam longint CycleLimit = 2_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_req_type = spf_pkg::ReqVertex;
    logic [3:0]  i_vertex_index = '0;
    logic [11:0] i_vertex_x = '0;
    logic [11:0] i_vertex_y = '0;
    logic [11:0] i_scan_y = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [4:0]  i_cfg_data = '0;
    logic        o_span_valid, o_no_span, o_last_span;
    logic [11:0] o_span_start, o_span_end, o_span_row;
    int          fail_count, pending;
    longint      cycle_count = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    scanline_polygon_span_fill_top dut (.*);

    spf_span_checker checker_i (
        .i_clk, .i_rst_n, .start, .busy, .i_req_type, .i_vertex_index,
        .i_vertex_x, .i_vertex_y, .i_scan_y, .i_cfg_valid,
        .i_cfg_ready(o_cfg_ready), .i_cfg_data,
        .i_span_valid(o_span_valid), .i_span_start(o_span_start),
        .i_span_end(o_span_end), .i_span_row(o_span_row),
        .i_no_span(o_no_span), .i_last_span(o_last_span),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("** scanline_polygon_span_fill_top: FAILED **");
            $finish;
        end
    end

    // one transfer on the request channel, after a random gap
    task automatic send_request(input logic req, input logic [3:0] idx,
                                input logic [11:0] x, input logic [11:0] y,
                                input logic [11:0] row, input bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) @(negedge i_clk);
        i_req_type     <= req;
        i_vertex_index <= idx;
        i_vertex_x     <= x;
        i_vertex_y     <= y;
        i_scan_y       <= row;
        start          <= 1'b1;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    task automatic put_vertex(input int idx, input int x, input int y);
        send_request(spf_pkg::ReqVertex, idx[3:0], x[11:0], y[11:0], 12'($urandom));
    endtask

    task automatic scan_row(input int row);
        send_request(spf_pkg::ReqScan, 4'($urandom), 12'($urandom), 12'($urandom),
                     row[11:0]);
    endtask

    // register written only when idle
    task automatic set_vertex_count(input int n);
        while (pending != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
        i_cfg_data  <= n[4:0];
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_polygon(input int n, input int span);
        for (int i = 0; i < n; i++)
            put_vertex(i, $urandom_range(0, span), $urandom_range(0, span));
    endtask

    initial begin
        int n, span, rows;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty polygon, extremes, horizontal edge, odd crossing
        scan_row(0);
        put_vertex(0, 0, 0);
        put_vertex(1, 4095, 0);
        put_vertex(2, 4095, 4095);
        put_vertex(3, 0, 4095);
        set_vertex_count(4);
        scan_row(0);
        scan_row(2047);
        scan_row(4094);
        scan_row(4095);
        // a write to a slot outside the count leaves the square intact
        put_vertex(15, 4095, 4095);
        put_vertex(4, 100, 2000);
        set_vertex_count(5);
        scan_row(1000);
        scan_row(2000);
        scan_row(3000);
        put_vertex(0, 4095, 0);
        put_vertex(1, 0, 4095);
        put_vertex(2, 4095, 1);
        set_vertex_count(3);
        scan_row(2048);
        scan_row(0);
        // full table of zigzags gives many crossings
        for (int i = 0; i < 16; i++)
            put_vertex(i, i * 273, (i % 2) ? 4095 : 0);
        set_vertex_count(31);
        scan_row(1234);
        set_vertex_count(16);
        scan_row(4000);

        // random polygons: mostly small, a few full
        while (rows < 190) begin
            n    = ($urandom_range(0, 7) == 0) ? 16 : $urandom_range(3, 8);
            span = ($urandom_range(0, 1)) ? 4095 : $urandom_range(8, 200);
            set_vertex_count(0);
            scan_row($urandom);
            rows++;
            random_polygon(n, span);
            if ($urandom_range(0, 3) == 0)
                put_vertex($urandom_range(0, 15), $urandom, $urandom);
            set_vertex_count(n);
            for (int r = 0; r < 8; r++) begin
                scan_row(($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, span));
                rows++;
            end
            if ($urandom_range(0, 9) == 0)
                while (pending != 0) @(negedge i_clk);
        end

        while (pending != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("** scanline_polygon_span_fill_top: PASSED **");
        else
            $display("** scanline_polygon_span_fill_top: FAILED **");
        $finish;
    end
endmodule
